// ----- hw/rtl/apfc_pkg.sv -----
// Package: shared constants and types for the audio packet flow control block.
package apfc_pkg;
    localparam int FLIGHT_DEPTH    = 64;
    localparam int FLOOR_WINDOW_MS = 5000;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PACKET_MS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_TO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_TO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACKLOG_MARGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_CEIL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_INIT    = 3'd5;

    localparam logic [2:0] V_SEND       = 3'd0;
    localparam logic [2:0] V_DROP       = 3'd1;
    localparam logic [2:0] V_SILENT     = 3'd2;
    localparam logic [2:0] V_CONF_OK    = 3'd3;
    localparam logic [2:0] V_CONF_IGNORE = 3'd4;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
        logic        packet_silent;
        logic [7:0]  confirm_block;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        close_stream;
        logic [7:0]  block_number;
        logic [15:0] backlog_ms;
        logic [31:0] round_trip_ms;
    } t_out_item;
endpackage

// ----- hw/rtl/apfc_in_if.sv -----
// Interface: input item channel.
interface apfc_in_if;
    logic                valid;
    logic                ready;
    apfc_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/apfc_out_if.sv -----
// Interface: result item channel.
interface apfc_out_if;
    logic                valid;
    logic                ready;
    apfc_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/audio_packet_flow_control_core.sv -----
// Top level: audio packet flow control with an in-flight ring in block RAM.
//
// Usage: one input channel carries transactions that are either an offered
// packet (action 0) or a client confirmation (action 1); each produces one
// result transaction on the output channel with a verdict, close flag, block
// number, backlog and round trip. Configuration registers are written through
// a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user must write
// them only while the block idles, as the block itself does not enforce this.
// One transaction is processed at a time. The ring is a memory with a
// registered read; the control walks it one entry at a time (read, then
// decide). A suppressed silent packet skips the ring; another packet first
// expires the timed-out entries at the head and then decides; a
// confirmation walks from the head until it matches an entry or has seen
// every entry. Backlog multiply is registered. A new input is taken in the
// cycle after the result leaves the output register; the output register
// holds its transaction while the receiver stalls, and the next input then
// waits. Reset clears head, count, block counter, silence state and floors;
// the ring contents need no clearing.
module audio_packet_flow_control_core #(
    parameter int FLIGHT_DEPTH    = apfc_pkg::FLIGHT_DEPTH,
    parameter int FLOOR_WINDOW_MS = apfc_pkg::FLOOR_WINDOW_MS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [apfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [apfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    apfc_in_if.sink                       in_ch,
    apfc_out_if.source                    out_ch
);
    localparam int AW = $clog2(FLIGHT_DEPTH);
    localparam int CW = $clog2(FLIGHT_DEPTH + 1);
    localparam logic [31:0] WIN = 32'(FLOOR_WINDOW_MS);

    typedef enum logic [3:0] {
        S_IDLE, S_PKT_RD, S_PKT_CHK, S_PKT_DEC, S_PKT_WAIT, S_CF_RD, S_CF_CHK, S_CF_DONE,
        S_OUT
    } t_state;

    // configuration
    logic [9:0]  r_packet_ms;
    logic [15:0] r_silence_to, r_confirm_to, r_backlog_margin, r_limit_ceiling, r_limit_initial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_ms      <= 10'd20;
            r_silence_to     <= 16'd1000;
            r_confirm_to     <= 16'd2000;
            r_backlog_margin <= 16'd200;
            r_limit_ceiling  <= 16'd500;
            r_limit_initial  <= 16'd300;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                apfc_pkg::REG_PACKET_MS:      r_packet_ms      <= i_cfg_data[9:0];
                apfc_pkg::REG_SILENCE_TO:     r_silence_to     <= i_cfg_data;
                apfc_pkg::REG_CONFIRM_TO:     r_confirm_to     <= i_cfg_data;
                apfc_pkg::REG_BACKLOG_MARGIN: r_backlog_margin <= i_cfg_data;
                apfc_pkg::REG_LIMIT_CEIL:     r_limit_ceiling  <= i_cfg_data;
                apfc_pkg::REG_LIMIT_INIT:     r_limit_initial  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ring memory: block number and send time per entry
    logic [39:0] mem [FLIGHT_DEPTH];
    logic [39:0] r_rd_data;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [39:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rd_data <= mem[mem_raddr];
    end

    t_state r_state;
    apfc_pkg::t_in_item r_in;
    logic [2:0]    r_verdict;
    logic [7:0]    r_block;
    logic [15:0]   r_backlog;
    logic [31:0]   r_rtt;
    logic          r_out_valid;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;          // walk offset from head
    logic [7:0]    r_next_block;
    logic [15:0]   r_silence;
    logic          r_idle;
    logic [16:0]   r_floor_now, r_floor_before;
    logic          r_fn_valid, r_fb_valid;
    logic [31:0]   r_window_start;
    logic [31:0]   r_prod;         // packet_ms * count, registered
    logic          r_close;

    logic [AW-1:0] walk_addr;
    logic [AW-1:0] tail_addr;
    logic [31:0]   age;
    logic [16:0]   sil_sum;
    logic [15:0]   sil_sat;
    logic [16:0]   floor_b;
    logic [15:0]   backlog_sat;
    logic [16:0]   fl_sel;
    logic          have_fl;
    logic [17:0]   lim_sum;
    logic [16:0]   limit0, limit;
    logic [31:0]   backlog_new;
    logic [AW:0]   walk_sum, tail_sum;

    assign walk_sum  = {1'b0, r_head} + (AW+1)'(r_idx);
    assign tail_sum  = {1'b0, r_head} + (AW+1)'(r_count);
    assign walk_addr = AW'(walk_sum >= (AW+1)'(FLIGHT_DEPTH) ? walk_sum - (AW+1)'(FLIGHT_DEPTH)
                                                               : walk_sum);
    assign tail_addr = AW'(tail_sum >= (AW+1)'(FLIGHT_DEPTH) ? tail_sum - (AW+1)'(FLIGHT_DEPTH)
                                                               : tail_sum);
    assign mem_raddr = walk_addr;
    assign age       = r_in.now_ms - r_rd_data[31:0];
    assign sil_sum   = {1'b0, r_silence} + 17'(r_packet_ms);
    assign sil_sat   = sil_sum[16] ? 16'hFFFF : sil_sum[15:0];
    assign floor_b   = (r_prod > 32'h1FFFF) ? 17'h1FFFF : r_prod[16:0];
    assign backlog_sat = (r_prod > 32'hFFFF) ? 16'hFFFF : r_prod[15:0];

    always_comb begin
        have_fl = r_fn_valid;
        fl_sel  = r_floor_now;
        if (r_fb_valid && (!r_fn_valid || r_floor_before < r_floor_now)) begin
            have_fl = 1'b1;
            fl_sel  = r_floor_before;
        end
        lim_sum = {1'b0, fl_sel} + 18'(r_backlog_margin);
        if (have_fl) limit0 = (lim_sum > 18'(r_limit_ceiling)) ? 17'(r_limit_ceiling)
                                                               : lim_sum[16:0];
        else         limit0 = 17'(r_limit_initial);
        limit = (limit0 < 17'(r_packet_ms)) ? 17'(r_packet_ms) : limit0;
        backlog_new = r_prod + 32'(r_packet_ms);
    end

    assign mem_we    = (r_state == S_PKT_DEC) && !(backlog_new > 32'(limit))
                       && (r_count < CW'(FLIGHT_DEPTH));
    assign mem_waddr = tail_addr;
    assign mem_wdata = {r_next_block, r_in.now_ms};

    assign in_ch.ready  = (r_state == S_IDLE) && !r_out_valid;
    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = {r_verdict, r_close, r_block, r_backlog, r_rtt};

    always_ff @(posedge i_clk) begin
        r_prod <= 32'(r_packet_ms) * 32'(r_count);
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_head         <= '0;
            r_count        <= '0;
            r_idx          <= '0;
            r_next_block   <= '0;
            r_silence      <= '0;
            r_idle         <= 1'b0;
            r_floor_now    <= '0;
            r_floor_before <= '0;
            r_fn_valid     <= 1'b0;
            r_fb_valid     <= 1'b0;
            r_window_start <= '0;
            r_close        <= 1'b0;
        end else begin
            if (r_out_valid && out_ch.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        r_in    <= in_ch.data;
                        r_idx   <= '0;
                        r_block <= '0;
                        r_rtt   <= '0;
                        if (!in_ch.data.action) begin
                            if (in_ch.data.packet_silent) begin
                                r_silence <= sil_sat;
                                if (sil_sat >= r_silence_to) begin
                                    r_close   <= !r_idle;
                                    r_idle    <= 1'b1;
                                    r_verdict <= apfc_pkg::V_SILENT;
                                    r_state   <= S_OUT;
                                end else begin
                                    r_close <= 1'b0;
                                    r_state <= S_PKT_RD;
                                end
                            end else begin
                                r_close   <= 1'b0;
                                r_silence <= '0;
                                r_idle    <= 1'b0;
                                r_state   <= S_PKT_RD;
                            end
                        end else begin
                            r_close <= 1'b0;
                            r_state <= S_CF_RD;
                        end
                    end
                end
                S_PKT_RD: begin
                    // read issued at head; check next cycle
                    r_state <= (r_count == '0) ? S_PKT_DEC : S_PKT_CHK;
                end
                S_PKT_CHK: begin
                    if (age > 32'(r_confirm_to)) begin
                        r_head  <= AW'(walk_sum + 1'b1 >= (AW+1)'(FLIGHT_DEPTH)
                                       ? walk_sum + 1'b1 - (AW+1)'(FLIGHT_DEPTH)
                                       : walk_sum + 1'b1);
                        r_count <= r_count - 1'b1;
                        r_state <= S_PKT_RD;
                    end else begin
                        r_state <= S_PKT_DEC;
                    end
                end
                S_PKT_DEC: begin
                    // r_prod reflects the count as it stood in the previous cycle
                    if (mem_we) begin
                        r_count <= r_count + 1'b1;
                        r_next_block <= r_next_block + 8'd1;
                        r_block   <= r_next_block;
                        r_verdict <= apfc_pkg::V_SEND;
                    end else begin
                        r_verdict <= apfc_pkg::V_DROP;
                    end
                    r_state <= S_PKT_WAIT;
                end
                S_PKT_WAIT: begin
                    // let r_prod pick up the new count
                    r_state <= S_OUT;
                end
                S_CF_RD: begin
                    if (r_idx == r_count) begin
                        r_verdict <= apfc_pkg::V_CONF_IGNORE;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CF_CHK;
                    end
                end
                S_CF_CHK: begin
                    if (r_rd_data[39:32] == r_in.confirm_block) begin
                        r_rtt     <= age;
                        r_verdict <= apfc_pkg::V_CONF_OK;
                        r_head  <= AW'(walk_sum + 1'b1 >= (AW+1)'(FLIGHT_DEPTH)
                                       ? walk_sum + 1'b1 - (AW+1)'(FLIGHT_DEPTH)
                                       : walk_sum + 1'b1);
                        r_count <= r_count - r_idx - 1'b1;
                        r_idx   <= '0;
                        if (r_in.now_ms - r_window_start > WIN) begin
                            r_floor_before <= r_floor_now;
                            r_fb_valid     <= r_fn_valid;
                            r_fn_valid     <= 1'b0;
                            r_floor_now    <= '0;
                            r_window_start <= r_in.now_ms;
                        end
                        r_state <= S_CF_DONE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_CF_RD;
                    end
                end
                S_CF_DONE: begin
                    // wait here so r_prod holds the new count
                    if (r_idx == '0) begin
                        r_idx <= CW'(1);
                    end else begin
                        if (!r_fn_valid || floor_b < r_floor_now) begin
                            r_floor_now <= floor_b;
                            r_fn_valid  <= 1'b1;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // r_prod now reflects final count
                    r_backlog   <= backlog_sat;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hw/rtl/apfc_checker.sv -----
// Checker: port-level properties of the flow control block, bound to the top.
module apfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_verdict,
    input logic [7:0]  out_block,
    input logic [31:0] out_rtt
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_verdict <= apfc_pkg::V_CONF_IGNORE)
        else $error("bad verdict");
    a_block0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_verdict != apfc_pkg::V_SEND |-> out_block == 8'd0)
        else $error("block number on non-send");
    a_rtt0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_verdict != apfc_pkg::V_CONF_OK |-> out_rtt == 32'd0)
        else $error("round trip on non-accept");
endmodule

bind audio_packet_flow_control_core apfc_checker u_apfc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_verdict(out_ch.data.verdict),
    .out_block  (out_ch.data.block_number),
    .out_rtt    (out_ch.data.round_trip_ms)
);

// ----- tb/audio_packet_flow_control_core_tb.sv -----
// Testbench: packet verdicts and confirmations checked against a predictor of the ring state.
module audio_packet_flow_control_core_tb;
    localparam int RING_N = apfc_pkg::FLIGHT_DEPTH;
    localparam int FLOOR_SAT = 32'h1FFFF;

    typedef struct {
        apfc_pkg::t_in_item  it;
        bit                  typed;
        apfc_pkg::t_out_item want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [apfc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [apfc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    apfc_in_if  in_ch ();
    apfc_out_if out_ch ();

    audio_packet_flow_control_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    always #10 i_clk = ~i_clk;

    // register copies
    int unsigned pkt_ms, silence_to, confirm_to, backlog_margin, limit_ceiling, limit_initial;
    // in-flight ring and flow state
    logic [7:0]  ring_blk [RING_N];
    int unsigned ring_time [RING_N];
    int unsigned ring_head, ring_cnt;
    logic [7:0]  next_blk;
    int unsigned silence_acc;
    bit          idle_flag;
    int unsigned floor_now, floor_prev, window_start;
    bit          floor_now_ok, floor_prev_ok;

    apfc_pkg::t_out_item verdict_q[$];
    int        err_cnt = 0;
    int        snd_idle = 26, rcv_idle = 46;

    task automatic note_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic void ring_pop();
        ring_head = (ring_head + 1) % RING_N;
        ring_cnt--;
    endfunction

    function automatic apfc_pkg::t_out_item predict_verdict(input apfc_pkg::t_in_item it);
        apfc_pkg::t_out_item r;
        int unsigned now, backlog, limit, fl, found, b;
        bit          have, hit, suppressed;
        r = '0;
        now = it.now_ms;
        if (!it.action) begin
            suppressed = 0;
            if (it.packet_silent) begin
                silence_acc += pkt_ms;
                if (silence_acc > 32'hFFFF) silence_acc = 32'hFFFF;
                if (silence_acc >= silence_to) begin
                    if (!idle_flag) begin
                        r.close_stream = 1'b1;
                        idle_flag = 1;
                    end
                    suppressed = 1;
                end
            end else begin
                silence_acc = 0;
                idle_flag = 0;
            end
            if (suppressed) begin
                r.verdict = apfc_pkg::V_SILENT;
            end else begin
                while (ring_cnt > 0 && (now - ring_time[ring_head]) > confirm_to) ring_pop();
                backlog = pkt_ms * ring_cnt + pkt_ms;
                have = floor_now_ok;
                fl = floor_now;
                if (floor_prev_ok && (!have || floor_prev < fl)) begin
                    have = 1;
                    fl = floor_prev;
                end
                if (have) begin
                    limit = fl + backlog_margin;
                    if (limit > limit_ceiling) limit = limit_ceiling;
                end else begin
                    limit = limit_initial;
                end
                if (limit < pkt_ms) limit = pkt_ms;
                if (backlog > limit || ring_cnt >= RING_N) begin
                    r.verdict = apfc_pkg::V_DROP;
                end else begin
                    ring_blk[(ring_head + ring_cnt) % RING_N] = next_blk;
                    ring_time[(ring_head + ring_cnt) % RING_N] = now;
                    ring_cnt++;
                    r.block_number = next_blk;
                    next_blk++;
                    r.verdict = apfc_pkg::V_SEND;
                end
            end
        end else begin
            hit = 0;
            found = 0;
            for (int i = 0; i < ring_cnt; i++) begin
                if (!hit && ring_blk[(ring_head + i) % RING_N] == it.confirm_block) begin
                    hit = 1;
                    found = i;
                end
            end
            if (!hit) begin
                r.verdict = apfc_pkg::V_CONF_IGNORE;
            end else begin
                r.round_trip_ms = now - ring_time[(ring_head + found) % RING_N];
                for (int i = 0; i <= found; i++) ring_pop();
                if ((now - window_start) > apfc_pkg::FLOOR_WINDOW_MS) begin
                    floor_prev = floor_now;
                    floor_prev_ok = floor_now_ok;
                    floor_now_ok = 0;
                    floor_now = 0;
                    window_start = now;
                end
                b = pkt_ms * ring_cnt;
                if (b > FLOOR_SAT) b = FLOOR_SAT;
                if (!floor_now_ok || b < floor_now) begin
                    floor_now = b;
                    floor_now_ok = 1;
                end
                r.verdict = apfc_pkg::V_CONF_OK;
            end
        end
        b = pkt_ms * ring_cnt;
        r.backlog_ms = (b > 32'hFFFF) ? 16'hFFFF : b[15:0];
        return r;
    endfunction

    // offer one transaction; prediction is made when it is accepted
    task automatic offer(input apfc_pkg::t_in_item it, input bit typed,
                         input apfc_pkg::t_out_item want);
        apfc_pkg::t_out_item p;
        while ($urandom_range(99) < snd_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        p = predict_verdict(it);
        verdict_q = {verdict_q, (typed ? want : p)};
    endtask

    task automatic apply_cfg(input int unsigned v[6]);
        in_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (140) @(posedge i_clk);
        for (int i = 0; i < 6; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= apfc_pkg::CFG_IDX_W'(i);
            i_cfg_data <= apfc_pkg::CFG_DATA_W'(v[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        pkt_ms         = v[apfc_pkg::REG_PACKET_MS] & 32'h3FF;
        silence_to     = v[apfc_pkg::REG_SILENCE_TO] & 32'hFFFF;
        confirm_to     = v[apfc_pkg::REG_CONFIRM_TO] & 32'hFFFF;
        backlog_margin = v[apfc_pkg::REG_BACKLOG_MARGIN] & 32'hFFFF;
        limit_ceiling  = v[apfc_pkg::REG_LIMIT_CEIL] & 32'hFFFF;
        limit_initial  = v[apfc_pkg::REG_LIMIT_INIT] & 32'hFFFF;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) out_ch.ready <= ($urandom_range(99) >= rcv_idle);

    always @(posedge i_clk) begin
        apfc_pkg::t_out_item w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (verdict_q.size() == 0) begin
                note_mismatch("result transaction with nothing expected");
            end else begin
                w = verdict_q[0];
                verdict_q.delete(0);
                if (out_ch.data.verdict !== w.verdict)
                    note_mismatch($sformatf("verdict %0d, want %0d",
                        out_ch.data.verdict, w.verdict));
                if (out_ch.data.close_stream !== w.close_stream)
                    note_mismatch($sformatf("close %0b, want %0b",
                        out_ch.data.close_stream, w.close_stream));
                if (out_ch.data.block_number !== w.block_number)
                    note_mismatch($sformatf("block %0d, want %0d",
                        out_ch.data.block_number, w.block_number));
                if (out_ch.data.backlog_ms !== w.backlog_ms)
                    note_mismatch($sformatf("backlog %0d, want %0d",
                        out_ch.data.backlog_ms, w.backlog_ms));
                if (out_ch.data.round_trip_ms !== w.round_trip_ms)
                    note_mismatch($sformatf("round trip %0d, want %0d",
                        out_ch.data.round_trip_ms, w.round_trip_ms));
            end
        end
    end

    initial begin
        #100000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_dir_row    dir_tab[$];
        int unsigned cfg_set[6][6];
        int unsigned t;
        bit          quiet_run;
        apfc_pkg::t_in_item it;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        pkt_ms = 20; silence_to = 1000; confirm_to = 2000;
        backlog_margin = 200; limit_ceiling = 500; limit_initial = 300;
        ring_head = 0; ring_cnt = 0; next_blk = '0;
        silence_acc = 0; idle_flag = 0;
        floor_now = 0; floor_prev = 0; floor_now_ok = 0; floor_prev_ok = 0;
        window_start = 0;

        // action, now, silent, block | typed | verdict, close, block, backlog, round trip
        dir_tab = '{
            '{'{1'b0, 32'd0, 1'b0, 8'd0}, 1'b1,
              '{apfc_pkg::V_SEND, 1'b0, 8'd0, 16'd20, 32'd0}},
            '{'{1'b1, 32'd5, 1'b0, 8'd0}, 1'b1,
              '{apfc_pkg::V_CONF_OK, 1'b0, 8'd0, 16'd0, 32'd5}},
            '{'{1'b1, 32'd6, 1'b1, 8'd255}, 1'b1,
              '{apfc_pkg::V_CONF_IGNORE, 1'b0, 8'd0, 16'd0, 32'd0}},
            '{'{1'b0, 32'd10, 1'b1, 8'd255},       1'b0, '0},
            '{'{1'b0, 32'd20, 1'b0, 8'h00},        1'b0, '0},
            '{'{1'b0, 32'd30, 1'b0, 8'h00},        1'b0, '0},
            '{'{1'b1, 32'd40, 1'b0, 8'd2},         1'b0, '0},
            '{'{1'b0, 32'hFFFF_FFFF, 1'b0, 8'hFF}, 1'b0, '0},
            '{'{1'b1, 32'd3, 1'b0, 8'd4},          1'b0, '0},
            '{'{1'b0, 32'd10000, 1'b0, 8'h00},     1'b0, '0},
            '{'{1'b1, 32'd10010, 1'b0, 8'd5},      1'b0, '0},
            '{'{1'b1, 32'd10020, 1'b0, 8'hAA},     1'b0, '0},
            '{'{1'b1, 32'd10030, 1'b1, 8'h55},     1'b0, '0},
            '{'{1'b0, 32'd10040, 1'b1, 8'h00},     1'b0, '0},
            '{'{1'b0, 32'd10050, 1'b1, 8'h00},     1'b0, '0},
            '{'{1'b0, 32'd10060, 1'b0, 8'h00},     1'b0, '0},
            '{'{1'b0, 32'h8000_0000, 1'b0, 8'h00}, 1'b0, '0},
            '{'{1'b1, 32'h8000_0001, 1'b0, 8'd7},  1'b0, '0},
            '{'{1'b1, 32'h8000_0002, 1'b0, 8'd6},  1'b0, '0}
        };
        // packet, silence, confirm, backlog, hard, startup
        cfg_set = '{
            '{1,    0,     65535, 65535, 65535, 65535},
            '{1023, 65535, 0,     0,     0,     0},
            '{10,   100,   300,   40,    120,   80},
            '{0,    50,    500,   0,     65535, 0},
            '{20,   1000,  2000,  200,   500,   300},
            '{700,  2100,  65535, 65535, 65535, 65535}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) offer(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);

        for (int ph = 0; ph < 6; ph++) begin
            apply_cfg(cfg_set[ph]);
            snd_idle = (ph < 2) ? 26 : (ph < 4) ? 46 : 0;
            rcv_idle = (ph < 2) ? 46 : (ph < 4) ? 26 : 0;
            t = $urandom;
            quiet_run = 0;
            for (int n = 0; n < 225; n++) begin
                t += $urandom_range(0, 30);
                if ($urandom_range(99) < 3) t += $urandom_range(0, 8000);
                if ($urandom_range(99) == 0) t = $urandom;
                if ($urandom_range(99) < 5) quiet_run = !quiet_run;
                it.action        = ($urandom_range(99) < 40);
                it.now_ms        = t;
                it.packet_silent = quiet_run ? ($urandom_range(9) != 0)
                                             : ($urandom_range(9) == 0);
                // mostly confirm a block that is really in flight
                if (ring_cnt > 0 && $urandom_range(99) < 80)
                    it.confirm_block =
                        ring_blk[(ring_head + $urandom_range(ring_cnt - 1)) % RING_N];
                else
                    it.confirm_block = 8'($urandom_range(255));
                offer(it, 1'b0, '0);
            end
        end
        in_ch.valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/apfc_pkg.sv
hw/rtl/apfc_in_if.sv
hw/rtl/apfc_out_if.sv
hw/rtl/audio_packet_flow_control_core.sv
hw/rtl/apfc_checker.sv
tb/audio_packet_flow_control_core_tb.sv
